// ===== hdl/spmta_pkg.sv =====
// ============================================================================
// spmta_pkg: shared types and constants for the sparse polynomial merge adder
// Holds the store depth, index widths, item kind codes, term record and the
// controller state type.
// ============================================================================
package spmta_pkg;

    // Store depth, terms per polynomial
    localparam int TERMS_MAX = 16;
    // Address bits into one store
    localparam int IDX_W = (TERMS_MAX > 1) ? $clog2(TERMS_MAX) : 1;
    // Count bits, able to hold TERMS_MAX itself
    localparam int CNT_W = $clog2(TERMS_MAX + 1);
    localparam logic [CNT_W-1:0] TERMS_FULL = CNT_W'(TERMS_MAX);

    // Input item kinds
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // One stored term
    typedef struct packed {
        logic signed [15:0] coef;
        logic        [15:0] expo;
    } t_term;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== hdl/spmta_in_if.sv =====
// ============================================================================
// spmta_in_if: input channel of the sparse polynomial merge adder
// Carries load and run items with a valid/ready handshake.
// ============================================================================
interface spmta_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic signed [15:0] coefficient;
    logic        [15:0] exponent;

    modport source (output valid, output kind, output coefficient, output exponent,
                    input ready);
    modport sink   (input valid, input kind, input coefficient, input exponent,
                    output ready);
endinterface

// ===== hdl/spmta_out_if.sv =====
// ============================================================================
// spmta_out_if: result channel of the sparse polynomial merge adder
// Carries merged terms with a valid/ready handshake.
// ============================================================================
interface spmta_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] sum_coefficient;
    logic        [15:0] term_exponent;
    logic               last_term;
    logic               terms_dropped;

    modport source (output valid, output sum_coefficient, output term_exponent,
                    output last_term, output terms_dropped, input ready);
    modport sink   (input valid, input sum_coefficient, input term_exponent,
                    input last_term, input terms_dropped, output ready);
endinterface

// ===== hdl/sparse_poly_term_merge_add_unit.sv =====
// ============================================================================
// sparse_poly_term_merge_add_unit: sorted merge adder for sparse polynomials
// Loads two term lists into two term stores and merges them on a run item.
// ============================================================================
// Usage:
//   i_in  : load items (kind 0 first list, kind 1 second list) and run items
//           (kind 2). Kind 3 is taken and ignored.
//   o_out : one transfer per merged term; last_term marks the final term and
//           terms_dropped reports a load that found its store full.
// Timing:
//   Loads are accepted back to back while idle. A run holds i_in.ready low
//   until the merge is done, one term per cycle while o_out.ready does not
//   stall the output register, paced by the single read port of each term
//   store. The run transfer moves the controller to ST_RUN, and the first
//   term is then registered into the output register.
//   Each store's read address is the next merge index, so the registered
//   read data is always the entry at the current index.
// Reset:
//   Both term counts and the drop flag clear; store contents are undefined
//   until loaded. No clearing pass is needed.
// Stall:
//   While o_out.ready is low with a term pending, the merge holds its
//   indices. Loads may be accepted while the final term still waits.
// ============================================================================
module sparse_poly_term_merge_add_unit
    import spmta_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    spmta_in_if.sink     i_in,
    spmta_out_if.source  o_out
);

    // Term stores
    t_term mem_a [TERMS_MAX];
    t_term mem_b [TERMS_MAX];
    t_term r_rd_a;
    t_term r_rd_b;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]   r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic               r_drop, n_drop;

    logic               r_out_valid, n_out_valid;
    logic signed [16:0] r_out_coef, n_out_coef;
    logic [15:0]        r_out_exp, n_out_exp;
    logic               r_out_last, n_out_last;
    logic               r_out_drop, n_out_drop;

    logic               in_xfer;
    logic               load_a, load_b;
    logic               out_free;
    logic               a_ok, b_ok;
    logic               emit;
    logic               emit_last;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign load_a   = in_xfer && (i_in.kind == KIND_LOAD_A) && (r_cnt_a < TERMS_FULL);
    assign load_b   = in_xfer && (i_in.kind == KIND_LOAD_B) && (r_cnt_b < TERMS_FULL);
    assign out_free = !r_out_valid || o_out.ready;
    assign a_ok     = r_i < r_cnt_a;
    assign b_ok     = r_j < r_cnt_b;

    assign i_in.ready            = (r_state == ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.sum_coefficient = r_out_coef;
    assign o_out.term_exponent   = r_out_exp;
    assign o_out.last_term       = r_out_last;
    assign o_out.terms_dropped   = r_out_drop;

    // Store write at the fill count, read at the next merge index
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            mem_a[r_cnt_a[IDX_W-1:0]] <= t_term'{coef: i_in.coefficient,
                                                 expo: i_in.exponent};
        end
        if (load_b) begin
            mem_b[r_cnt_b[IDX_W-1:0]] <= t_term'{coef: i_in.coefficient,
                                                 expo: i_in.exponent};
        end
        r_rd_a <= mem_a[n_i[IDX_W-1:0]];
        r_rd_b <= mem_b[n_j[IDX_W-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_coef <= n_out_coef;
        r_out_exp  <= n_out_exp;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    // Next state: loads, merge step, output register
    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_coef  = r_out_coef;
        n_out_exp   = r_out_exp;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        emit        = 1'b0;
        emit_last   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in.kind)
                        KIND_LOAD_A: begin
                            if (load_a) n_cnt_a = r_cnt_a + 1'b1;
                            else        n_drop  = 1'b1;
                        end
                        KIND_LOAD_B: begin
                            if (load_b) n_cnt_b = r_cnt_b + 1'b1;
                            else        n_drop  = 1'b1;
                        end
                        KIND_RUN: begin
                            n_state = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (!a_ok && !b_ok) begin
                    // both lists empty: finish without a term
                    n_state = ST_IDLE;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_i     = '0;
                    n_j     = '0;
                    n_drop  = 1'b0;
                end else if (out_free) begin
                    emit       = 1'b1;
                    n_out_drop = r_drop;
                    if (a_ok && b_ok && (r_rd_a.expo == r_rd_b.expo)) begin
                        n_out_coef = {r_rd_a.coef[15], r_rd_a.coef}
                                   + {r_rd_b.coef[15], r_rd_b.coef};
                        n_out_exp  = r_rd_a.expo;
                        n_i        = r_i + 1'b1;
                        n_j        = r_j + 1'b1;
                    end else if (a_ok && (!b_ok || (r_rd_a.expo > r_rd_b.expo))) begin
                        n_out_coef = {r_rd_a.coef[15], r_rd_a.coef};
                        n_out_exp  = r_rd_a.expo;
                        n_i        = r_i + 1'b1;
                    end else begin
                        n_out_coef = {r_rd_b.coef[15], r_rd_b.coef};
                        n_out_exp  = r_rd_b.expo;
                        n_j        = r_j + 1'b1;
                    end
                    emit_last   = !(n_i < r_cnt_a) && !(n_j < r_cnt_b);
                    n_out_valid = 1'b1;
                    n_out_last  = emit_last;
                    if (emit_last) begin
                        // run done: empty both stores and clear the drop flag
                        n_state = ST_IDLE;
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Merge indices never pass their fill counts
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt_a) && (r_j <= r_cnt_b))
        else $error("merge index beyond fill count");

    // Fill counts never pass the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= TERMS_FULL) && (r_cnt_b <= TERMS_FULL))
        else $error("fill count beyond store depth");

    // Indices rest at zero while idle so the first read is entry zero
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_i == '0) && (r_j == '0))
        else $error("merge index not cleared in idle");

    // An accepted load into store A with room advances its count
    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_a |=> (r_cnt_a == $past(r_cnt_a) + 1'b1))
        else $error("load did not advance fill count");

    // The final term ends the run and empties both stores
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == ST_IDLE) && (r_cnt_a == '0)
                                && (r_cnt_b == '0) && r_out_valid && r_out_last)
        else $error("run did not finish after final term");

endmodule
